@@ design/ffba_pkg.sv @@
package ffba_pkg;

  localparam int TAG_W = 13;
  localparam int OFF_W = 12;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_OOM = 1'b1;

  typedef struct packed {
    logic             func;
    logic [TAG_W-1:0] alloc_size;
    logic [OFF_W-1:0] free_offset;
  } req_t;

  typedef struct packed {
    logic             status;
    logic [OFF_W-1:0] block_offset;
    logic [TAG_W-1:0] freed_size;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_FILL,
    ST_FREAD,
    ST_CLEAR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic init_step;
    logic load_req;
    logic decode;
    logic scan_step;
    logic fill_start;
    logic fill_step;
    logic free_load;
    logic clr_step;
    logic rsp_load;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic req_free;
    logic alloc_bad;
    logic off_bad;
    logic scan_found;
    logic scan_end;
    logic cnt_last;
    logic free_zero;
    logic out_busy;
  } sts_t;

endpackage

@@ design/ffba_ram.sv @@
module ffba_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ design/ffba_ctrl.sv @@
module ffba_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ffba_pkg::sts_t  sts_i,
  output ffba_pkg::cmd_t  cmd_o
);

  ffba_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffba_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ffba_pkg::ST_INIT: begin
        cmd_o.init_step = 1'b1;
        if (sts_i.init_last) begin
          state_d = ffba_pkg::ST_IDLE;
        end
      end
      ffba_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = ffba_pkg::ST_DECODE;
        end
      end
      ffba_pkg::ST_DECODE: begin
        cmd_o.decode = 1'b1;
        if (sts_i.req_free) begin
          state_d = sts_i.off_bad ? ffba_pkg::ST_DONE : ffba_pkg::ST_FREAD;
        end else begin
          state_d = sts_i.alloc_bad ? ffba_pkg::ST_DONE : ffba_pkg::ST_SCAN;
        end
      end
      ffba_pkg::ST_SCAN: begin
        priority if (sts_i.scan_found) begin
          cmd_o.fill_start = 1'b1;
          state_d          = ffba_pkg::ST_FILL;
        end else if (sts_i.scan_end) begin
          state_d = ffba_pkg::ST_DONE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ffba_pkg::ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ffba_pkg::ST_DONE;
        end
      end
      ffba_pkg::ST_FREAD: begin
        cmd_o.free_load = 1'b1;
        state_d = sts_i.free_zero ? ffba_pkg::ST_DONE : ffba_pkg::ST_CLEAR;
      end
      ffba_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ffba_pkg::ST_DONE;
        end
      end
      ffba_pkg::ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.rsp_load = 1'b1;
          state_d        = ffba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ffba_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/ffba_dp.sv @@
module ffba_dp #(
  parameter int POOL_BYTES = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ffba_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ffba_pkg::rsp_t  out_data_o,
  input  ffba_pkg::cmd_t  cmd_i,
  output ffba_pkg::sts_t  sts_o
);

  localparam int TW = ffba_pkg::TAG_W;
  localparam int AW = $clog2(POOL_BYTES);
  localparam int SW = (AW + 1 > TW + 1) ? AW + 1 : TW + 1;

  ffba_pkg::req_t req_q;
  ffba_pkg::rsp_t res_q;
  ffba_pkg::rsp_t out_q;
  logic           out_valid_q;

  logic [AW:0]   ptr_q;
  logic [AW:0]   cnt_q;
  logic [AW-1:0] chk_pos_q;
  logic          chk_vld_q;
  logic [TW-1:0] run_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [TW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [TW-1:0] ram_rdata;

  logic [SW-1:0] len_ext;
  logic [SW-1:0] off_ext;
  logic [SW-1:0] tag_ext;
  logic [SW-1:0] room;
  logic [SW-1:0] flen;
  logic [SW-1:0] start_w;
  logic [TW-1:0] run_inc;
  logic          tag_free;
  logic          scan_hit;
  logic          ptr_in_pool;

  assign len_ext     = SW'(req_q.alloc_size);
  assign off_ext     = SW'(req_q.free_offset);
  assign tag_ext     = SW'(ram_rdata);
  assign room        = SW'(POOL_BYTES) - off_ext;
  assign flen        = (tag_ext > room) ? room : tag_ext;
  assign start_w     = SW'(chk_pos_q) + SW'(1) - len_ext;
  assign run_inc     = run_q + 1'b1;
  assign tag_free    = (ram_rdata == '0);
  assign scan_hit    = chk_vld_q && tag_free && (run_inc == req_q.alloc_size);
  assign ptr_in_pool = (ptr_q != (AW + 1)'(POOL_BYTES));

  always_comb begin
    sts_o            = '0;
    sts_o.init_last  = (ptr_q == (AW + 1)'(POOL_BYTES - 1));
    sts_o.req_free   = (req_q.func == ffba_pkg::FUNC_FREE);
    sts_o.alloc_bad  = (req_q.alloc_size == '0) || (len_ext > SW'(POOL_BYTES));
    sts_o.off_bad    = (off_ext >= SW'(POOL_BYTES));
    sts_o.scan_found = scan_hit;
    sts_o.scan_end   = chk_vld_q && !scan_hit && (chk_pos_q == AW'(POOL_BYTES - 1));
    sts_o.cnt_last   = (cnt_q == (AW + 1)'(1));
    sts_o.free_zero  = (flen == '0);
    sts_o.out_busy   = out_valid_q && !out_ready_i;
  end

  // tag store port selection
  assign ram_we    = cmd_i.init_step | cmd_i.fill_step | cmd_i.clr_step;
  assign ram_waddr = ptr_q[AW-1:0];
  assign ram_wdata = cmd_i.fill_step ? req_q.alloc_size : '0;
  assign ram_raddr = cmd_i.decode ? off_ext[AW-1:0] : ptr_q[AW-1:0];

  ffba_ram #(
    .WIDTH(TW),
    .DEPTH(POOL_BYTES)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      cnt_q       <= '0;
      chk_vld_q   <= 1'b0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      priority if (cmd_i.init_step || cmd_i.fill_step || cmd_i.clr_step) begin
        ptr_q <= ptr_q + 1'b1;
        cnt_q <= cnt_q - 1'b1;
      end else if (cmd_i.decode) begin
        ptr_q     <= '0;
        run_q     <= '0;
        chk_vld_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        if (ptr_in_pool) begin
          ptr_q <= ptr_q + 1'b1;
        end
        chk_vld_q <= ptr_in_pool;
        if (chk_vld_q) begin
          run_q <= tag_free ? run_inc : '0;
        end
      end else if (cmd_i.fill_start) begin
        ptr_q     <= start_w[AW:0];
        cnt_q     <= len_ext[AW:0];
        chk_vld_q <= 1'b0;
      end else if (cmd_i.free_load) begin
        ptr_q <= off_ext[AW:0];
        cnt_q <= flen[AW:0];
      end else begin
        ptr_q <= ptr_q;
      end

      if (cmd_i.rsp_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_data_i;
    end
    if (cmd_i.scan_step) begin
      chk_pos_q <= ptr_q[AW-1:0];
    end
    priority if (cmd_i.decode) begin
      res_q.status       <= (req_q.func == ffba_pkg::FUNC_FREE) ? ffba_pkg::STATUS_OK
                                                                 : ffba_pkg::STATUS_OOM;
      res_q.block_offset <= '0;
      res_q.freed_size   <= '0;
    end else if (cmd_i.fill_start) begin
      res_q.status       <= ffba_pkg::STATUS_OK;
      res_q.block_offset <= start_w[ffba_pkg::OFF_W-1:0];
    end else if (cmd_i.free_load) begin
      res_q.freed_size <= flen[TW-1:0];
    end else begin
      res_q <= res_q;
    end
    if (cmd_i.rsp_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ design/first_fit_byte_allocator.sv @@
// first-fit byte allocator over a pool of POOL_BYTES bytes, one tag per byte
// input channel: in_valid_i / in_ready_o with an allocate or free request in
// in_data_i; output channel: out_valid_o / out_ready_i with one response per
// request in out_data_o (status, block offset, freed length)
// after reset a clearing pass writes every tag to zero, one tag a cycle, so
// in_ready_o stays low until the pass is over
// allocate: the request is decoded, then the tag memory is scanned one byte a
// cycle from offset zero; once a free run of len bytes is found, the run is
// tagged and the response handed over; a miss answers once the scan reaches
// the last byte of the pool; a zero or oversize length answers straight after
// decode
// free: the tag at the offset is read, then the bytes of the block are cleared
// one after another and the response handed over
// the tag memory has one write port and one read port;
// one request is worked on at a time
// the response sits in an output register, so a new request is accepted while
// the previous response waits; a stalled receiver only holds the block once
// the next response is ready to be handed over
module first_fit_byte_allocator #(
  parameter int POOL_BYTES = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ffba_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ffba_pkg::rsp_t out_data_o
);

  ffba_pkg::cmd_t cmd;
  ffba_pkg::sts_t sts;

  ffba_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ffba_dp #(
    .POOL_BYTES(POOL_BYTES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule
